@@ design/fpe_pkg.sv @@
package fpe_pkg;

	localparam logic [1:0] CMD_LOAD_VIEW = 2'd0;
	localparam logic [1:0] CMD_LOAD_PROJ = 2'd1;
	localparam logic [1:0] CMD_COMPUTE   = 2'd2;

	localparam int PLANE_COUNT = 6;
	localparam logic [2:0] LAST_PLANE = 3'(PLANE_COUNT - 1);

	localparam int ACC_W = 51;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	function automatic q16_t sat32(input acc_t v);
		q16_t r;
		if (v > acc_t'(32'sh7fffffff)) r = 32'sh7fffffff;
		else if (v < -acc_t'(33'sh080000000)) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] abs32(input q16_t v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

@@ design/frustum_plane_extractor_unit.sv @@
// Load commands are taken one per cycle; ready stays high between them.
// A compute command works through the planes one after another: the shared
// multiplier forms the clip entries each plane needs, the square root settles
// one bit per cycle and the divider retires one quotient bit per cycle for each
// component; a zero-length plane skips the divider.
// No command is taken during a compute, which holds while the result register is full; reset clears both stores and empties it.
module frustum_plane_extractor_unit
	import fpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [1:0]  row,
	input  logic [1:0]  col,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  plane_index,
	output logic signed [31:0] normal_x,
	output logic signed [31:0] normal_y,
	output logic signed [31:0] normal_z,
	output logic signed [31:0] distance,
	output logic        degenerate,
	output logic        last
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_ACC   = 4'd2;
	localparam logic [3:0] ST_COMB  = 4'd3;
	localparam logic [3:0] ST_SQM   = 4'd4;
	localparam logic [3:0] ST_SQA   = 4'd5;
	localparam logic [3:0] ST_SQRT  = 4'd6;
	localparam logic [3:0] ST_DINIT = 4'd7;
	localparam logic [3:0] ST_DSTEP = 4'd8;
	localparam logic [3:0] ST_DFIN  = 4'd9;
	localparam logic [3:0] ST_EMIT  = 4'd10;

	q16_t view_q [16];
	q16_t proj_q [16];
	q16_t comp_q [4];
	q16_t res_q [4];

	logic [3:0]  state_q;
	logic [2:0]  plane_q;
	logic [1:0]  j_q, k_q;
	logic        half_q;
	acc_t        acc_q;
	q16_t        clipa_q, clipb_q;
	logic signed [65:0] prod_q;
	logic [63:0] s_q, rem_q, root_q, bitv_q;
	logic        degen_q;
	logic [32:0] drem_q;
	logic [47:0] dq_q;
	logic [5:0]  cnt_q;

	logic [1:0]  mcol;
	logic signed [32:0] mul_a, mul_b;
	acc_t        psh, acc_nx;
	acc_t        comb;
	logic [63:0] sq_t;
	logic [32:0] dtry;
	logic        out_free;
	logic        emit_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid || out_ready;
	assign emit_fire = (state_q == ST_EMIT) && out_free;
	assign mcol = half_q ? plane_q[2:1] : 2'd3;

	always_comb begin
		if (state_q == ST_SQM) begin
			mul_a = {1'b0, abs32(comp_q[j_q])};
			mul_b = mul_a;
		end else begin
			mul_a = {view_q[{j_q, k_q}][31], view_q[{j_q, k_q}]};
			mul_b = {proj_q[{k_q, mcol}][31], proj_q[{k_q, mcol}]};
		end
	end

	assign psh = {prod_q[65], prod_q[65:16]};
	assign acc_nx = acc_q + psh;
	assign comb = plane_q[0] ? (acc_t'(clipa_q) - acc_t'(clipb_q))
	                         : (acc_t'(clipa_q) + acc_t'(clipb_q));
	assign sq_t = root_q + bitv_q;
	assign dtry = {drem_q[31:0], dq_q[47]};

	// matrix stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				view_q[i] <= '0;
				proj_q[i] <= '0;
			end
		end else if (in_valid && in_ready) begin
			if (command == CMD_LOAD_VIEW) view_q[{row, col}] <= value;
			if (command == CMD_LOAD_PROJ) proj_q[{row, col}] <= value;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit_fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plane_q <= '0;
			j_q <= '0;
			k_q <= '0;
			half_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && command == CMD_COMPUTE) begin
						plane_q <= '0;
						j_q <= '0;
						k_q <= '0;
						half_q <= 1'b0;
						acc_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						acc_q <= '0;
						if (half_q) begin
							clipb_q <= sat32(acc_nx);
							state_q <= ST_COMB;
						end else begin
							clipa_q <= sat32(acc_nx);
							state_q <= ST_MUL;
						end
						half_q <= !half_q;
					end else begin
						acc_q <= acc_nx;
						state_q <= ST_MUL;
					end
				end
				ST_COMB: begin
					comp_q[j_q] <= sat32(comb);
					j_q <= j_q + 2'd1;
					if (j_q == 2'd3) begin
						s_q <= '0;
						state_q <= ST_SQM;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_SQM: state_q <= ST_SQA;
				ST_SQA: begin
					s_q <= s_q + prod_q[63:0];
					if (j_q == 2'd2) begin
						j_q <= '0;
						rem_q <= s_q + prod_q[63:0];
						root_q <= '0;
						bitv_q <= 64'd1 << 62;
						state_q <= ST_SQRT;
					end else begin
						j_q <= j_q + 2'd1;
						state_q <= ST_SQM;
					end
				end
				ST_SQRT: begin
					if (bitv_q == '0) begin
						degen_q <= (root_q == '0);
						if (root_q == '0) begin
							for (int i = 0; i < 4; i++) res_q[i] <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DINIT;
						end
					end else begin
						if (rem_q >= sq_t) begin
							rem_q <= rem_q - sq_t;
							root_q <= (root_q >> 1) + bitv_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bitv_q <= bitv_q >> 2;
					end
				end
				ST_DINIT: begin
					dq_q <= {abs32(comp_q[j_q]), 16'd0};
					drem_q <= '0;
					cnt_q <= '0;
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					// shift in one numerator bit, retire one quotient bit
					if (dtry >= {1'b0, root_q[31:0]}) begin
						drem_q <= dtry - {1'b0, root_q[31:0]};
						dq_q <= {dq_q[46:0], 1'b1};
					end else begin
						drem_q <= dtry;
						dq_q <= {dq_q[46:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd47) state_q <= ST_DFIN;
				end
				ST_DFIN: begin
					if (comp_q[j_q][31])
						res_q[j_q] <= (dq_q > 48'h80000000) ? 32'sh80000000
						                                    : (~dq_q[31:0] + 32'd1);
					else
						res_q[j_q] <= (dq_q > 48'h7fffffff) ? 32'sh7fffffff : dq_q[31:0];
					j_q <= j_q + 2'd1;
					state_q <= (j_q == 2'd3) ? ST_EMIT : ST_DINIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						plane_index <= plane_q;
						normal_x <= res_q[0];
						normal_y <= res_q[1];
						normal_z <= res_q[2];
						distance <= res_q[3];
						degenerate <= degen_q;
						last <= (plane_q == LAST_PLANE);
						j_q <= '0;
						k_q <= '0;
						half_q <= 1'b0;
						acc_q <= '0;
						plane_q <= plane_q + 3'd1;
						state_q <= (plane_q == LAST_PLANE) ? ST_IDLE : ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_last_plane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> plane_index == LAST_PLANE)
		else $error("last flag on wrong plane");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == 0 && normal_y == 0 &&
			normal_z == 0 && distance == 0)
		else $error("degenerate plane carries nonzero data");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DSTEP |-> root_q[31:0] != '0)
		else $error("divide by zero length");

endmodule

@@ test/tb_frustum_plane_extractor_unit.sv @@
module tb_frustum_plane_extractor_unit;
	import fpe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int HOLD_CYCLES = 5000;

	typedef struct {
		logic [1:0] command;
		logic [1:0] row;
		logic [1:0] col;
		logic signed [31:0] value;
		bit drain_first;
	} cmd_item_t;

	typedef struct {
		logic [2:0] plane_index;
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [31:0] ofs;
		logic degenerate;
		logic last;
	} plane_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] command, row, col;
	logic signed [31:0] value;
	logic [2:0] plane_index;
	logic signed [31:0] normal_x, normal_y, normal_z, distance;
	logic degenerate, last;

	cmd_item_t pending_cmds[$];
	cmd_item_t cur_cmd;
	plane_t expected_planes[$];
	logic signed [31:0] view_m[16];
	logic signed [31:0] proj_m[16];
	int accepted_cmds;
	int planes_seen;
	int hold_left;
	bit hold_done;
	int errors;
	bit stim_done;

	frustum_plane_extractor_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .row(row), .col(col), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.plane_index(plane_index), .normal_x(normal_x), .normal_y(normal_y),
		.normal_z(normal_z), .distance(distance), .degenerate(degenerate), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] s);
		logic [63:0] r, probe;
		r = '0;
		probe = 64'd1 << 62;
		while (probe > s) probe = probe >> 2;
		while (probe != 0) begin
			if (s >= r + probe) begin
				s = s - (r + probe);
				r = (r >> 1) + probe;
			end else begin
				r = r >> 1;
			end
			probe = probe >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] unit_scale(input longint x, input logic [63:0] m);
		logic [63:0] ux, q;
		ux = (x < 0) ? 64'(-x) : 64'(x);
		q = (ux << 16) / m;
		return 32'(clamp32((x < 0) ? -longint'(q) : longint'(q)));
	endfunction

	// Apply one accepted command to the shadow matrices; queue planes on compute.
	task automatic apply_command(input cmd_item_t it);
		longint clip[16];
		longint comp[4];
		longint acc, prod, a;
		logic [63:0] s, m;
		plane_t pl;
		int idx, axis;
		idx = int'({it.row, it.col});
		case (it.command)
			CMD_LOAD_VIEW: view_m[idx] = it.value;
			CMD_LOAD_PROJ: proj_m[idx] = it.value;
			CMD_COMPUTE: begin
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++) begin
						acc = 0;
						for (int k = 0; k < 4; k++) begin
							prod = longint'(view_m[r*4+k]) * longint'(proj_m[k*4+c]);
							acc += prod >>> 16;
						end
						clip[r*4+c] = clamp32(acc);
					end
				for (int p = 0; p < PLANE_COUNT; p++) begin
					axis = p >> 1;
					for (int j = 0; j < 4; j++)
						comp[j] = clamp32((p & 1) ? clip[j*4+3] - clip[j*4+axis]
							: clip[j*4+3] + clip[j*4+axis]);
					s = '0;
					for (int j = 0; j < 3; j++) begin
						a = (comp[j] < 0) ? -comp[j] : comp[j];
						s += 64'(a) * 64'(a);
					end
					m = root64(s);
					pl.plane_index = 3'(p);
					pl.last = (p == PLANE_COUNT - 1);
					pl.degenerate = (m == 0);
					if (m == 0) begin
						pl.nx = '0; pl.ny = '0; pl.nz = '0; pl.ofs = '0;
					end else begin
						pl.nx = unit_scale(comp[0], m);
						pl.ny = unit_scale(comp[1], m);
						pl.nz = unit_scale(comp[2], m);
						pl.ofs = unit_scale(comp[3], m);
					end
					expected_planes.push_back(pl);
				end
			end
			default: ;
		endcase
	endtask

	function automatic int idle_pct(input bit sender);
		if (accepted_cmds < 110) return sender ? 33 : 62;
		if (accepted_cmds < 220) return sender ? 62 : 33;
		return 0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_NONE;
			row <= 2'd0;
			col <= 2'd0;
			value <= 32'sd0;
			accepted_cmds <= 0;
		end else begin
			if (in_valid && in_ready) begin
				apply_command(cur_cmd);
				accepted_cmds <= accepted_cmds + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() > 0
						&& !(pending_cmds[0].drain_first && expected_planes.size() > 0)
						&& $urandom_range(99) >= idle_pct(1'b1)) begin
					cur_cmd = pending_cmds.pop_front();
					in_valid <= 1'b1;
					command <= cur_cmd.command;
					row <= cur_cmd.row;
					col <= cur_cmd.col;
					value <= cur_cmd.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			planes_seen <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				planes_seen <= planes_seen + 1;
				if (expected_planes.size() == 0) begin
					$display("%0t: unexpected plane %0d", $time, plane_index);
					errors++;
				end else begin
					plane_t e;
					e = expected_planes.pop_front();
					if (plane_index !== e.plane_index || normal_x !== e.nx
							|| normal_y !== e.ny || normal_z !== e.nz
							|| distance !== e.ofs || degenerate !== e.degenerate
							|| last !== e.last) begin
						$display("%0t: expected idx=%0d n=(%h %h %h) d=%h deg=%b last=%b",
							$time, e.plane_index, e.nx, e.ny, e.nz, e.ofs,
							e.degenerate, e.last);
						$display("%0t: actual   idx=%0d n=(%h %h %h) d=%h deg=%b last=%b",
							$time, plane_index, normal_x, normal_y, normal_z, distance,
							degenerate, last);
						errors++;
					end
				end
			end
			// one long hold-off while commands keep coming
			if (!hold_done && planes_seen >= 30) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
			end
		end
	end

	task automatic add_cmd(input logic [1:0] c, input int r, input int k,
			input logic [31:0] v, input bit drain = 1'b0);
		cmd_item_t it;
		it.command = c;
		it.row = 2'(r);
		it.col = 2'(k);
		it.value = v;
		it.drain_first = drain;
		pending_cmds.push_back(it);
	endtask

	function automatic logic [31:0] rand_value(input int kind);
		case (kind)
			0: return $urandom();
			1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
			2: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(512)) - 256);
		endcase
	endfunction

	initial begin
		int n, kind;
		arst_n = 1'b0;
		errors = 0;
		stim_done = 1'b0;
		for (int i = 0; i < 16; i++) begin
			view_m[i] = 0;
			proj_m[i] = 0;
		end
		// zero matrices give degenerate planes
		add_cmd(CMD_COMPUTE, 0, 0, 0);
		add_cmd(CMD_NONE, 3, 3, 32'hffffffff);
		add_cmd(CMD_LOAD_VIEW, 0, 0, 32'h7fffffff);
		add_cmd(CMD_LOAD_VIEW, 3, 3, 32'h80000000);
		add_cmd(CMD_LOAD_PROJ, 0, 0, 32'h7fffffff);
		add_cmd(CMD_LOAD_PROJ, 3, 3, 32'h80000000);
		add_cmd(CMD_COMPUTE, 3, 3, 32'h7fffffff);
		for (int i = 0; i < 4; i++) begin
			add_cmd(CMD_LOAD_VIEW, i, i, 32'h00010000);
			add_cmd(CMD_LOAD_PROJ, i, i, (i == 2) ? 32'hffff0000 : 32'h00010000);
		end
		add_cmd(CMD_LOAD_PROJ, 3, 2, 32'hffff0000);
		add_cmd(CMD_LOAD_PROJ, 2, 3, 32'h80000000);
		add_cmd(CMD_COMPUTE, 1, 2, 0);
		add_cmd(CMD_NONE, 0, 0, 0);
		while (pending_cmds.size() < 330) begin
			kind = $urandom_range(9);
			kind = (kind < 3) ? 0 : (kind < 7) ? 1 : (kind < 8) ? 2 : 3;
			n = $urandom_range(20, 1);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(19) == 0)
					add_cmd(CMD_NONE, $urandom_range(3), $urandom_range(3), $urandom());
				else
					add_cmd($urandom_range(1) ? CMD_LOAD_PROJ : CMD_LOAD_VIEW,
						$urandom_range(3), $urandom_range(3), rand_value(kind));
			end
			// a compute queued while the queue holds 201 to 222 items waits until every plane is out
			add_cmd(CMD_COMPUTE, $urandom_range(3), $urandom_range(3), $urandom(),
				pending_cmds.size() > 200 && pending_cmds.size() <= 222);
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_cmds.size() == 0 && !in_valid);
		wait (expected_planes.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_planes.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#30ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ files.f @@
design/fpe_pkg.sv
design/frustum_plane_extractor_unit.sv
test/tb_frustum_plane_extractor_unit.sv
